/* hdl/svf_lowpass_filter_top_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the state-variable low-pass filter
// Shared property forms; each use names its own label.
// ----------------------------------------------------------------------------
`ifndef SVF_LOWPASS_FILTER_TOP_ASSERT_SVH
`define SVF_LOWPASS_FILTER_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is high
`define SVF_ASSERT_IMPL(name, clk_s, rst_s, ante, cons) \
  name: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error("svf: same-cycle check failed");

// Next-cycle implication, disabled while reset is high
`define SVF_ASSERT_NEXT(name, clk_s, rst_s, ante, cons) \
  name: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error("svf: next-cycle check failed");

`endif

/* hdl/svf_pkg.sv */
// ----------------------------------------------------------------------------
// svf_pkg
// Types, constants and tables shared by the state-variable filter modules.
// ----------------------------------------------------------------------------
package svf_pkg;

  // Default sizes
  localparam int SAMPLE_WIDTH_DEF = 16;
  localparam int ACC_WIDTH_DEF    = 48;
  localparam int OUT_WIDTH        = 32;

  // Configuration port
  localparam int CFG_ADDR_WIDTH = 5;
  localparam int CFG_DATA_WIDTH = 32;

  // Register field widths
  localparam int CUTOFF_WIDTH = 13;
  localparam int RES_WIDTH    = 5;
  localparam int FRAC_WIDTH   = 3;

  // Coefficients and shifts
  localparam int K_WIDTH          = 9;
  localparam int DAMP_WIDTH       = 8;
  localparam int COEF_WIDTH       = 17;
  localparam int SHIFT_WIDTH      = 5;
  localparam int SHIFT_BASE       = 24;
  localparam int DAMP_SHIFT_EXTRA = 7;
  localparam int K_BASE           = 256;
  localparam logic [CUTOFF_WIDTH-1:0] MANT_MASK = 13'h1FF;
  localparam int FRAC_MIN         = 3;
  localparam int FRAC_MAX         = 5;

  // Product terms per sample
  localparam int NUM_OPS = 4;

  typedef enum logic [2:0] {
    REG_CUTOFF,
    REG_RESONANCE,
    REG_FRACTION,
    REG_ROUND_INPUT,
    REG_ROUND_LOWTERM,
    REG_ROUND_DAMPING,
    REG_ROUND_BANDTERM,
    REG_UPDATE_ORDER
  } reg_idx_t;

  typedef enum logic [1:0] {
    RND_FLOOR,
    RND_TO_ZERO,
    RND_HALF_AWAY,
    RND_HALF_UP
  } rmode_t;

  typedef enum logic [1:0] {
    OP_INPUT,
    OP_LOWTERM,
    OP_DAMPING,
    OP_BANDTERM
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEL,
    ST_MLO,
    ST_MHI,
    ST_PSUM,
    ST_RND,
    ST_ACC,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic [CUTOFF_WIDTH-1:0] cutoff_code;
    logic [RES_WIDTH-1:0]    resonance_index;
    logic [FRAC_WIDTH-1:0]   fraction_bits;
    rmode_t                  round_input;
    rmode_t                  round_lowterm;
    rmode_t                  round_damping;
    rmode_t                  round_bandterm;
    logic                    update_order;
  } cfg_t;

  // Controller to datapath commands
  typedef struct packed {
    logic load;
    logic sel;
    logic mul_lo;
    logic mul_hi;
    logic psum;
    logic rnd;
    logic acc;
    logic commit;
    op_t  op;
  } cmd_t;

  // Damping factor per resonance index
  function automatic logic [DAMP_WIDTH-1:0] damp_factor(input logic [RES_WIDTH-1:0] idx);
    logic [DAMP_WIDTH-1:0] d;
    case (idx)
      5'd0:  d = 8'd192;
      5'd1:  d = 8'd176;
      5'd2:  d = 8'd160;
      5'd3:  d = 8'd144;
      5'd4:  d = 8'd128;
      5'd5:  d = 8'd120;
      5'd6:  d = 8'd112;
      5'd7:  d = 8'd104;
      5'd8:  d = 8'd96;
      5'd9:  d = 8'd88;
      5'd10: d = 8'd80;
      5'd11: d = 8'd72;
      5'd12: d = 8'd64;
      5'd13: d = 8'd60;
      5'd14: d = 8'd56;
      5'd15: d = 8'd52;
      5'd16: d = 8'd48;
      5'd17: d = 8'd44;
      5'd18: d = 8'd40;
      5'd19: d = 8'd36;
      5'd20: d = 8'd32;
      5'd21: d = 8'd30;
      5'd22: d = 8'd28;
      5'd23: d = 8'd26;
      5'd24: d = 8'd24;
      5'd25: d = 8'd22;
      5'd26: d = 8'd20;
      5'd27: d = 8'd18;
      5'd28: d = 8'd16;
      5'd29: d = 8'd15;
      5'd30: d = 8'd14;
      5'd31: d = 8'd13;
      default: d = 8'd192;
    endcase
    return d;
  endfunction

  // Gain from the cutoff mantissa
  function automatic logic [K_WIDTH-1:0] k_gain(input logic [CUTOFF_WIDTH-1:0] cutoff);
    logic [CUTOFF_WIDTH-1:0] mant;
    mant = (cutoff & MANT_MASK) >> 1;
    return K_WIDTH'(K_BASE) + K_WIDTH'(mant);
  endfunction

  // Product term issued at a given step for each update order
  function automatic op_t op_at(input logic order, input logic [1:0] idx);
    op_t op;
    if (!order) begin
      case (idx)
        2'd0:    op = OP_INPUT;
        2'd1:    op = OP_LOWTERM;
        2'd2:    op = OP_DAMPING;
        default: op = OP_BANDTERM;
      endcase
    end else begin
      case (idx)
        2'd0:    op = OP_BANDTERM;
        2'd1:    op = OP_INPUT;
        2'd2:    op = OP_LOWTERM;
        default: op = OP_DAMPING;
      endcase
    end
    return op;
  endfunction

endpackage

/* hdl/svf_in_if.sv */
// ----------------------------------------------------------------------------
// svf_in_if
// Input sample channel: valid/ready with one signed sample per beat.
// ----------------------------------------------------------------------------
interface svf_in_if
  import svf_pkg::*;
#(
  parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
);
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] sample_in;

  modport source (output valid, output sample_in, input ready);
  modport sink   (input valid, input sample_in, output ready);
endinterface

/* hdl/svf_out_if.sv */
// ----------------------------------------------------------------------------
// svf_out_if
// Result channel: valid/ready with one signed 32-bit sample per beat.
// ----------------------------------------------------------------------------
interface svf_out_if
  import svf_pkg::*;
;
  logic                        valid;
  logic                        ready;
  logic signed [OUT_WIDTH-1:0] sample_out;

  modport source (output valid, output sample_out, input ready);
  modport sink   (input valid, input sample_out, output ready);
endinterface

/* hdl/svf_regs.sv */
// ----------------------------------------------------------------------------
// svf_regs
// Configuration register file behind an APB-style write/read port.
// ----------------------------------------------------------------------------
module svf_regs
  import svf_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [CFG_ADDR_WIDTH-1:0] paddr,
  input  logic [CFG_DATA_WIDTH-1:0] pwdata,
  output logic [CFG_DATA_WIDTH-1:0] prdata,
  output logic                      pready,
  output cfg_t                      cfg
);

  reg_idx_t reg_idx;
  logic     wr_en;

  assign pready  = 1'b1;
  assign reg_idx = reg_idx_t'(paddr[4:2]);
  assign wr_en   = psel & penable & pwrite & pready;

  // Write a register on the access beat
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.cutoff_code     <= '0;
      cfg.resonance_index <= '0;
      cfg.fraction_bits   <= FRAC_WIDTH'(FRAC_MIN);
      cfg.round_input     <= RND_FLOOR;
      cfg.round_lowterm   <= RND_FLOOR;
      cfg.round_damping   <= RND_FLOOR;
      cfg.round_bandterm  <= RND_FLOOR;
      cfg.update_order    <= 1'b0;
    end else if (wr_en) begin
      case (reg_idx)
        REG_CUTOFF:         cfg.cutoff_code     <= pwdata[CUTOFF_WIDTH-1:0];
        REG_RESONANCE:      cfg.resonance_index <= pwdata[RES_WIDTH-1:0];
        REG_FRACTION:       cfg.fraction_bits   <= pwdata[FRAC_WIDTH-1:0];
        REG_ROUND_INPUT:    cfg.round_input     <= rmode_t'(pwdata[1:0]);
        REG_ROUND_LOWTERM:  cfg.round_lowterm   <= rmode_t'(pwdata[1:0]);
        REG_ROUND_DAMPING:  cfg.round_damping   <= rmode_t'(pwdata[1:0]);
        REG_ROUND_BANDTERM: cfg.round_bandterm  <= rmode_t'(pwdata[1:0]);
        REG_UPDATE_ORDER:   cfg.update_order    <= pwdata[0];
        default: ;
      endcase
    end
  end

  // Read back the addressed register
  always_comb begin
    case (reg_idx)
      REG_CUTOFF:         prdata = CFG_DATA_WIDTH'(cfg.cutoff_code);
      REG_RESONANCE:      prdata = CFG_DATA_WIDTH'(cfg.resonance_index);
      REG_FRACTION:       prdata = CFG_DATA_WIDTH'(cfg.fraction_bits);
      REG_ROUND_INPUT:    prdata = CFG_DATA_WIDTH'(cfg.round_input);
      REG_ROUND_LOWTERM:  prdata = CFG_DATA_WIDTH'(cfg.round_lowterm);
      REG_ROUND_DAMPING:  prdata = CFG_DATA_WIDTH'(cfg.round_damping);
      REG_ROUND_BANDTERM: prdata = CFG_DATA_WIDTH'(cfg.round_bandterm);
      REG_UPDATE_ORDER:   prdata = CFG_DATA_WIDTH'(cfg.update_order);
      default:            prdata = '0;
    endcase
  end

endmodule

/* hdl/svf_ctrl.sv */
// ----------------------------------------------------------------------------
// svf_ctrl
// Sequencer: steps four product terms through the shared datapath per sample
// and owns the input ready and result valid flags.
// ----------------------------------------------------------------------------
`include "svf_lowpass_filter_top_assert.svh"

module svf_ctrl
  import svf_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  output logic out_valid,
  input  logic out_ready,
  input  logic update_order,
  output cmd_t cmd
);

  localparam logic [1:0] LAST_OP = 2'(NUM_OPS - 1);

  state_t     state;
  state_t     state_next;
  logic [1:0] op_idx;

  // State register, term counter and result flag
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      op_idx    <= 2'd0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load) begin
        op_idx <= 2'd0;
      end else if (cmd.acc && op_idx != LAST_OP) begin
        op_idx <= op_idx + 2'd1;
      end
      if (cmd.commit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.op     = op_at(update_order, op_idx);
    in_ready   = (state == ST_IDLE);
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_SEL;
        end
      end
      ST_SEL: begin
        cmd.sel    = 1'b1;
        state_next = ST_MLO;
      end
      ST_MLO: begin
        cmd.mul_lo = 1'b1;
        state_next = ST_MHI;
      end
      ST_MHI: begin
        cmd.mul_hi = 1'b1;
        state_next = ST_PSUM;
      end
      ST_PSUM: begin
        cmd.psum   = 1'b1;
        state_next = ST_RND;
      end
      ST_RND: begin
        cmd.rnd    = 1'b1;
        state_next = ST_ACC;
      end
      ST_ACC: begin
        cmd.acc    = 1'b1;
        state_next = (op_idx == LAST_OP) ? ST_DONE : ST_SEL;
      end
      ST_DONE: begin
        // Hold until the output register is free
        if (!out_valid || out_ready) begin
          cmd.commit = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  `SVF_ASSERT_NEXT(a_load_starts_first_term, clk, rst, cmd.load, state == ST_SEL && op_idx == 2'd0)
  `SVF_ASSERT_IMPL(a_commit_slot_free, clk, rst, cmd.commit, !out_valid || out_ready)
  `SVF_ASSERT_NEXT(a_last_term_done, clk, rst, state == ST_ACC && op_idx == LAST_OP, state == ST_DONE)
  `SVF_ASSERT_NEXT(a_commit_raises_valid, clk, rst, cmd.commit, out_valid && state == ST_IDLE)

endmodule

/* hdl/svf_dp.sv */
// ----------------------------------------------------------------------------
// svf_dp
// Datapath: filter state, one shared split multiplier, rounding and the
// band/low accumulation, driven step by step from the sequencer.
// ----------------------------------------------------------------------------
module svf_dp
  import svf_pkg::*;
#(
  parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
  parameter int ACC_WIDTH    = ACC_WIDTH_DEF
)(
  input  logic                           clk,
  input  logic                           rst,
  input  cfg_t                           cfg,
  input  cmd_t                           cmd,
  input  logic signed [SAMPLE_WIDTH-1:0] sample_in,
  output logic signed [OUT_WIDTH-1:0]    sample_out
);

  localparam int HALF_WIDTH = (ACC_WIDTH + 1) / 2;
  localparam int PROD_WIDTH = HALF_WIDTH + COEF_WIDTH;
  localparam int FULL_WIDTH = ACC_WIDTH + COEF_WIDTH;

  // Coefficient and shift decode
  logic [K_WIDTH-1:0]     k;
  logic [SHIFT_WIDTH-1:0] shift_k;
  logic [SHIFT_WIDTH-1:0] shift_d;
  logic [1:0]             frac_sel;
  logic [2:0]             in_shift;

  // Filter state and working sums
  logic signed [ACC_WIDTH-1:0] band;
  logic signed [ACC_WIDTH-1:0] low;
  logic signed [ACC_WIDTH-1:0] sum;
  logic signed [ACC_WIDTH-1:0] nlow;
  logic signed [ACC_WIDTH-1:0] xs;
  logic signed [ACC_WIDTH-1:0] sample_ext;
  logic [COEF_WIDTH-1:0]       kq;

  // Per-term operands
  logic signed [ACC_WIDTH-1:0] opnd;
  logic [COEF_WIDTH-1:0]       coef_sel;
  logic [SHIFT_WIDTH-1:0]      shamt_sel;
  rmode_t                      mode_sel;
  logic [ACC_WIDTH-1:0]        mag;
  logic                        neg;
  logic [COEF_WIDTH-1:0]       coef;
  logic [SHIFT_WIDTH-1:0]      shamt;
  rmode_t                      mode;

  // Multiplier and rounding
  logic [HALF_WIDTH-1:0] mul_a;
  logic [PROD_WIDTH-1:0] mul_p;
  logic [PROD_WIDTH-1:0] plo;
  logic [PROD_WIDTH-1:0] phi;
  logic [FULL_WIDTH-1:0] p;
  logic [SHIFT_WIDTH-1:0] sh_half;
  logic [FULL_WIDTH-1:0] p_q;
  logic [FULL_WIDTH-1:0] p_h;
  logic [FULL_WIDTH-1:0] below_mask;
  logic                  half;
  logic                  below;
  logic                  inc;
  logic [ACC_WIDTH-1:0]  qmag;
  logic                  qneg;
  logic                  sub;

  // Output rescale
  logic signed [ACC_WIDTH-1:0] low_scaled;
  logic [ACC_WIDTH-1:0]        out_full;

  assign k       = k_gain(cfg.cutoff_code);
  assign shift_k = SHIFT_WIDTH'(SHIFT_BASE) - SHIFT_WIDTH'(cfg.cutoff_code[12:9]);
  assign shift_d = shift_k + SHIFT_WIDTH'(DAMP_SHIFT_EXTRA);

  // Clamp state fraction bits to the supported range
  always_comb begin
    if (cfg.fraction_bits < FRAC_WIDTH'(FRAC_MIN)) begin
      frac_sel = 2'd0;
    end else if (cfg.fraction_bits > FRAC_WIDTH'(FRAC_MAX)) begin
      frac_sel = 2'(FRAC_MAX - FRAC_MIN);
    end else begin
      frac_sel = 2'(cfg.fraction_bits - FRAC_WIDTH'(FRAC_MIN));
    end
  end

  assign in_shift   = 3'(FRAC_MIN) + 3'(frac_sel);
  assign sample_ext = ACC_WIDTH'(sample_in);

  // Select operand, coefficient, shift and rounding for the current term
  always_comb begin
    case (cmd.op)
      OP_INPUT: begin
        opnd = xs;   coef_sel = COEF_WIDTH'(k); shamt_sel = shift_k;
        mode_sel = cfg.round_input;
      end
      OP_LOWTERM: begin
        opnd = nlow; coef_sel = COEF_WIDTH'(k); shamt_sel = shift_k;
        mode_sel = cfg.round_lowterm;
      end
      OP_DAMPING: begin
        opnd = band; coef_sel = kq;             shamt_sel = shift_d;
        mode_sel = cfg.round_damping;
      end
      OP_BANDTERM: begin
        opnd = sum;  coef_sel = COEF_WIDTH'(k); shamt_sel = shift_k;
        mode_sel = cfg.round_bandterm;
      end
      default: begin
        opnd = xs;   coef_sel = COEF_WIDTH'(k); shamt_sel = shift_k;
        mode_sel = cfg.round_input;
      end
    endcase
  end

  // Shared multiplier: low half of the magnitude, then the high half
  assign mul_a = cmd.mul_hi ? HALF_WIDTH'(mag[ACC_WIDTH-1:HALF_WIDTH]) : mag[HALF_WIDTH-1:0];
  assign mul_p = PROD_WIDTH'(mul_a) * PROD_WIDTH'(coef);

  // Rounding of the exact product
  assign sh_half    = shamt - SHIFT_WIDTH'(1);
  assign p_q        = p >> shamt;
  assign p_h        = p >> sh_half;
  assign below_mask = (FULL_WIDTH'(1) << sh_half) - FULL_WIDTH'(1);
  assign half       = p_h[0];
  assign below      = |(p & below_mask);

  always_comb begin
    if (!neg) begin
      inc = mode[1] & half;
    end else begin
      case (mode)
        RND_FLOOR:     inc = half | below;
        RND_TO_ZERO:   inc = 1'b0;
        RND_HALF_AWAY: inc = half;
        RND_HALF_UP:   inc = half & below;
        default:       inc = 1'b0;
      endcase
    end
  end

  // Subtract when the term is subtracted and positive, or added and negative
  assign sub = ((cmd.op == OP_LOWTERM) || (cmd.op == OP_DAMPING)) ^ qneg;

  assign low_scaled = nlow >>> frac_sel;
  assign out_full   = ACC_WIDTH'(0) - (ACC_WIDTH'(low_scaled) << 1);

  // Filter state: cleared on reset, replaced at commit
  always_ff @(posedge clk) begin
    if (rst) begin
      band <= '0;
      low  <= '0;
    end else if (cmd.commit) begin
      band <= sum;
      low  <= nlow;
    end
  end

  // Working registers
  always_ff @(posedge clk) begin
    // Latch the sample and seed the working sums
    if (cmd.load) begin
      xs   <= sample_ext << in_shift;
      kq   <= COEF_WIDTH'(k) * COEF_WIDTH'(damp_factor(cfg.resonance_index));
      sum  <= band;
      nlow <= low;
    end
    // Take the magnitude of the operand
    if (cmd.sel) begin
      neg   <= opnd[ACC_WIDTH-1];
      mag   <= opnd[ACC_WIDTH-1] ? ACC_WIDTH'(0) - ACC_WIDTH'(opnd) : ACC_WIDTH'(opnd);
      coef  <= coef_sel;
      shamt <= shamt_sel;
      mode  <= mode_sel;
    end
    if (cmd.mul_lo) begin
      plo <= mul_p;
    end
    if (cmd.mul_hi) begin
      phi <= mul_p;
    end
    // Join the partial products
    if (cmd.psum) begin
      p <= FULL_WIDTH'(plo) + (FULL_WIDTH'(phi) << HALF_WIDTH);
    end
    if (cmd.rnd) begin
      qmag <= p_q[ACC_WIDTH-1:0] + ACC_WIDTH'(inc);
      qneg <= neg;
    end
    // Accumulate the rounded term
    if (cmd.acc) begin
      if (cmd.op == OP_BANDTERM) begin
        nlow <= sub ? nlow - $signed(qmag) : nlow + $signed(qmag);
      end else begin
        sum <= sub ? sum - $signed(qmag) : sum + $signed(qmag);
      end
    end
    if (cmd.commit) begin
      sample_out <= out_full[OUT_WIDTH-1:0];
    end
  end

endmodule

/* hdl/svf_lowpass_filter_top.sv */
// ----------------------------------------------------------------------------
// svf_lowpass_filter_top
// State-variable low-pass filter with APB-style configuration.
//
//   channel    dir   beat payload             handshake
//   sample_ch  in    sample_in  (signed 16)   valid / ready
//   result_ch  out   sample_out (signed 32)   valid / ready
//   config     in    APB-style write/read     psel, penable, pready
//
// Each sample is accepted, then its four product terms each pass select, two
// multiplier halves, partial sum, round and accumulate on the single shared
// multiplier, then it commits; the next sample is accepted only after that.
// Reset (rst, synchronous) clears the band and low state and restores the
// register defaults. A result waits in the output register; the next sample
// is accepted meanwhile and its commit holds until that result is taken.
// ----------------------------------------------------------------------------
module svf_lowpass_filter_top
  import svf_pkg::*;
#(
  parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
  parameter int ACC_WIDTH    = ACC_WIDTH_DEF
)(
  input  logic                      clk,
  input  logic                      rst,
  svf_in_if.sink                    sample_ch,
  svf_out_if.source                 result_ch,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [CFG_ADDR_WIDTH-1:0] paddr,
  input  logic [CFG_DATA_WIDTH-1:0] pwdata,
  output logic [CFG_DATA_WIDTH-1:0] prdata,
  output logic                      pready
);

  cfg_t cfg;
  cmd_t cmd;
  logic in_ready;
  logic out_valid;

  assign sample_ch.ready = in_ready;
  assign result_ch.valid = out_valid;

  // Configuration registers
  svf_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Sequencer
  svf_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (sample_ch.valid),
    .in_ready     (in_ready),
    .out_valid    (out_valid),
    .out_ready    (result_ch.ready),
    .update_order (cfg.update_order),
    .cmd          (cmd)
  );

  // Arithmetic
  svf_dp #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH),
    .ACC_WIDTH    (ACC_WIDTH)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .cmd        (cmd),
    .sample_in  (sample_ch.sample_in),
    .sample_out (result_ch.sample_out)
  );

endmodule
